// File: rtl/core/psff_pkg.sv
package psff_pkg;

   localparam int ID_W   = 32;
   localparam int TICK_W = 32;
   localparam int OP_W   = 2;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_ACCEPT   = 2'd0;
   localparam op_type OP_ACTIVATE = 2'd1;
   localparam op_type OP_RETIRE   = 2'd2;

   // Half of the serial number space; a gap at or above it counts as older.
   localparam logic [TICK_W-1:0] SERIAL_HALF = 32'h8000_0000;

   typedef struct packed {
      logic [ID_W-1:0]   peer;
      logic [TICK_W-1:0] tick;
      logic              has_tick;
      logic              retired;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan_read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

   function automatic logic tick_is_newer(input logic [TICK_W-1:0] fresh,
                                          input logic [TICK_W-1:0] old);
      logic [TICK_W-1:0] gap;
      gap = fresh - old;
      return (gap != '0) && (gap < SERIAL_HALF);
   endfunction

endpackage

// File: rtl/core/psff_ram.sv
module psff_ram #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/psff_ctrl.sv
module psff_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  psff_pkg::status_type   status,
   output psff_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_LAST   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      busy          = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            busy       = 1'b0;
            cmd.commit = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_commit_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |-> $past(state_ff) == S_LAST)
      else $error("commit reached without draining the scan");

   a_start_enters_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == S_SCAN)
      else $error("accepted request did not start a scan");

   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !status.scan_last) |=> state_ff == S_SCAN)
      else $error("scan left before the last slot was read");

endmodule

// File: rtl/core/psff_datapath.sv
module psff_datapath #(
   parameter int PEER_SLOTS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  psff_pkg::cmd_type                cmd,
   output psff_pkg::status_type             status,
   input  logic [psff_pkg::OP_W-1:0]        req_op,
   input  logic [psff_pkg::ID_W-1:0]        req_peer_id,
   input  logic [psff_pkg::TICK_W-1:0]      req_server_tick,
   output logic                             rsp_valid,
   output logic                             rsp_accepted
);

   localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int EW = $bits(psff_pkg::entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(PEER_SLOTS - 1);

   // Captured request.
   psff_pkg::op_type              op_ff;
   logic [psff_pkg::ID_W-1:0]     id_ff;
   logic [psff_pkg::TICK_W-1:0]   tick_ff;

   // Scan control.
   logic [IW-1:0]                 cnt_ff;
   logic                          rd_valid_ff;
   logic [IW-1:0]                 rd_idx_ff;

   // Scan results.
   logic                          hit_ff;
   logic [IW-1:0]                 hit_idx_ff;
   psff_pkg::entry_type           hit_entry_ff;
   logic                          free_ff;
   logic [IW-1:0]                 free_idx_ff;

   // One valid bit per slot; a slot never written reads as empty.
   logic [PEER_SLOTS-1:0]         valid_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_accepted_ff;

   logic [EW-1:0]                 rd_raw;
   psff_pkg::entry_type           rd_entry;
   logic                          rd_match;
   logic                          rd_free;

   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   psff_pkg::entry_type           wr_entry;
   logic                          acc;

   psff_ram #(
      .WIDTH (EW),
      .DEPTH (PEER_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan_read),
      .rd_addr (cnt_ff),
      .rd_data (rd_raw)
   );

   assign status.scan_last = (cnt_ff == LAST_IDX);

   always_comb begin
      rd_entry = valid_ff[rd_idx_ff] ? psff_pkg::entry_type'(rd_raw) : '0;
      rd_match = (rd_entry.peer == id_ff);
      rd_free  = (rd_entry.peer == '0) || rd_entry.retired;
   end

   // Decision and write-back for the scanned request.
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = hit_idx_ff;
      wr_entry = '{peer: id_ff, tick: '0, has_tick: 1'b0, retired: 1'b0};
      acc      = 1'b0;
      if (cmd.commit && id_ff != '0) begin
         case (op_ff)
            psff_pkg::OP_ACCEPT: begin
               if (hit_ff && !hit_entry_ff.retired &&
                   (!hit_entry_ff.has_tick ||
                    psff_pkg::tick_is_newer(tick_ff, hit_entry_ff.tick))) begin
                  wr_en             = 1'b1;
                  wr_entry.tick     = tick_ff;
                  wr_entry.has_tick = 1'b1;
                  acc               = 1'b1;
               end
            end
            psff_pkg::OP_ACTIVATE: begin
               if (hit_ff) begin
                  wr_en = hit_entry_ff.retired;
               end else if (free_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = free_idx_ff;
               end
            end
            psff_pkg::OP_RETIRE: begin
               if (hit_ff) begin
                  wr_en             = 1'b1;
                  wr_entry.tick     = hit_entry_ff.tick;
                  wr_entry.has_tick = hit_entry_ff.has_tick;
                  wr_entry.retired  = 1'b1;
               end else if (free_ff) begin
                  wr_en            = 1'b1;
                  wr_addr          = free_idx_ff;
                  wr_entry.retired = 1'b1;
               end
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         id_ff   <= req_peer_id;
         tick_ff <= req_server_tick;
      end
      if (rd_valid_ff && !hit_ff && rd_match) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_entry_ff <= rd_entry;
      end
      if (rd_valid_ff && !hit_ff && !rd_match && !free_ff && rd_free) begin
         free_idx_ff <= rd_idx_ff;
      end
      rd_idx_ff       <= cnt_ff;
      rsp_accepted_ff <= acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.scan_read;
         rsp_valid_ff <= cmd.commit;
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.scan_read && !status.scan_last) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.load) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (rd_valid_ff && !hit_ff) begin
            if (rd_match) begin
               hit_ff <= 1'b1;
            end else if (rd_free) begin
               free_ff <= 1'b1;
            end
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_accepted_ff;

   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rd_valid_ff)
      else $error("commit while a slot read is still in flight");

   a_accept_only_for_accept_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_accepted_ff) |-> $past(op_ff) == psff_pkg::OP_ACCEPT)
      else $error("accepted flag raised for a non-accept operation");

   a_hit_is_stored: assert property (@(posedge clock) disable iff (reset)
      (hit_ff && id_ff != '0) |-> valid_ff[hit_idx_ff])
      else $error("nonzero peer matched a slot that was never written");

endmodule

// File: rtl/core/peer_sequence_freshness_filter.sv
// Channel   Ports                                           Handshake
// --------  ----------------------------------------------  ------------------------------
// request   req_op, req_peer_id, req_server_tick            taken when start && !busy
// response  rsp_accepted                                    rsp_valid strobe, one cycle
//
// Each request scans the whole peer table, one slot per cycle through the
// single read port of the slot memory, then decides and writes back once.
// The response strobe is registered from the commit step, and a new request
// can be taken no earlier than the commit step of the one before it.
// Reset clears a per-slot valid bit at once, so the table reads as empty
// right away; there is no clearing pass. The receiver cannot stall: every
// response is shown for exactly one cycle.
module peer_sequence_freshness_filter #(
   parameter int PEER_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [psff_pkg::OP_W-1:0]     req_op,
   input  logic [psff_pkg::ID_W-1:0]     req_peer_id,
   input  logic [psff_pkg::TICK_W-1:0]   req_server_tick,
   output logic                          rsp_valid,
   output logic                          rsp_accepted
);

   // Commands from the sequencer and scan status back to it.
   psff_pkg::cmd_type    cmd;
   psff_pkg::status_type status;

   // The sequencer walks idle, scan, last read and commit. Busy drops in the
   // commit cycle as well, so the next request overlaps the write-back.
   psff_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath holds the slot memory, the valid bits, the first-match and
   // first-free trackers and the serial number compare.
   psff_datapath #(
      .PEER_SLOTS (PEER_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_peer_id     (req_peer_id),
      .req_server_tick (req_server_tick),
      .rsp_valid       (rsp_valid),
      .rsp_accepted    (rsp_accepted)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

// Testbench for the per-peer tick freshness filter.
//
// The testbench keeps its own copy of the peer slot table and works out the
// accepted bit of every request at the moment the request is taken. The
// expected bits wait in a queue. A monitor compares every response strobe
// against the oldest waiting entry. Directed requests come first: serial
// order at the wrap point and at half the tick space, the zero peer id and
// the unused op, and retire and revive. Random traffic over pools of peer
// ids follows, with two pools large enough to fill the table.
module testbench;

   localparam int TABLE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int POOL_MAX    = 32;
   localparam int REPORT_MAX  = 10;

   // Op 3 is unused, and the block ignores it.
   localparam psff_pkg::op_type OP_UNUSED = 2'd3;

   typedef struct packed {
      psff_pkg::op_type                op;
      logic [psff_pkg::ID_W-1:0]       peer;
      logic [psff_pkg::TICK_W-1:0]     tick;
      logic                            accepted;
   } verdict_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [psff_pkg::OP_W-1:0]       req_op = '0;
   logic [psff_pkg::ID_W-1:0]       req_peer_id = '0;
   logic [psff_pkg::TICK_W-1:0]     req_server_tick = '0;
   logic                            rsp_valid;
   logic                            rsp_accepted;

   // This is the testbench's own view of the slot table. The expected
   // verdict of each request comes from this copy.
   psff_pkg::entry_type             peer_slots [TABLE_DEPTH];
   verdict_type                     pending_verdicts [$];
   verdict_type                     oldest_verdict;

   logic [psff_pkg::ID_W-1:0]       id_pool [POOL_MAX];
   logic [psff_pkg::TICK_W-1:0]     pool_tick [POOL_MAX];
   int                              pool_size = 1;

   int                              cycle_count = 0;
   int                              failure_count = 0;
   bit                              gaps_enabled = 1'b1;

   peer_sequence_freshness_filter #(
      .PEER_SLOTS(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_peer_id(req_peer_id),
      .req_server_tick(req_server_tick),
      .rsp_valid(rsp_valid),
      .rsp_accepted(rsp_accepted)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The run is cut off here at the cycle limit, as when the block stops producing responses.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic note_failure(input string what);
      if (failure_count < REPORT_MAX)
         $display("ERROR at cycle %0d: %s", cycle_count, what);
      failure_count++;
   endtask

   function automatic void clear_peer_slots();
      int i;
      for (i = 0; i < TABLE_DEPTH; i++)
         peer_slots[i] = '0;
   endfunction

   function automatic void claim_slot(input int idx, input logic [psff_pkg::ID_W-1:0] id,
                                      input logic retired);
      peer_slots[idx].peer     = id;
      peer_slots[idx].tick     = '0;
      peer_slots[idx].has_tick = 1'b0;
      peer_slots[idx].retired  = retired;
   endfunction

   // This updates the table copy for one request and returns the accepted
   // bit. The scan stops at the first slot that holds the peer. A free slot
   // counts only if it lies before that match, and free means empty or
   // retired.
   function automatic logic predict_freshness(input psff_pkg::op_type op,
                                              input logic [psff_pkg::ID_W-1:0] id,
                                              input logic [psff_pkg::TICK_W-1:0] tick);
      int i;
      int hit;
      int free_idx;
      logic [psff_pkg::TICK_W-1:0] gap;
      logic passed;
      hit = -1;
      free_idx = -1;
      passed = 1'b0;
      if (id == '0 || op == OP_UNUSED)
         return 1'b0;
      for (i = 0; i < TABLE_DEPTH && hit < 0; i++) begin
         if (peer_slots[i].peer == id)
            hit = i;
         else if ((peer_slots[i].peer == '0 || peer_slots[i].retired) && free_idx < 0)
            free_idx = i;
      end
      case (op)
         psff_pkg::OP_ACCEPT: begin
            if (hit >= 0 && !peer_slots[hit].retired) begin
               // Serial order: newer means the wrapped gap is nonzero and
               // below half the tick space.
               gap = tick - peer_slots[hit].tick;
               if (!peer_slots[hit].has_tick ||
                   (gap != '0 && gap < psff_pkg::SERIAL_HALF)) begin
                  peer_slots[hit].tick     = tick;
                  peer_slots[hit].has_tick = 1'b1;
                  passed = 1'b1;
               end
            end
         end
         psff_pkg::OP_ACTIVATE: begin
            // A live match stays as it is. A retired match is revived with
            // its tick history cleared.
            if (hit >= 0) begin
               if (peer_slots[hit].retired)
                  claim_slot(hit, id, 1'b0);
            end else if (free_idx >= 0) begin
               claim_slot(free_idx, id, 1'b0);
            end
         end
         psff_pkg::OP_RETIRE: begin
            // An unknown peer takes a slot that is already retired. If the
            // table is full, nothing changes.
            if (hit >= 0)
               peer_slots[hit].retired = 1'b1;
            else if (free_idx >= 0)
               claim_slot(free_idx, id, 1'b1);
         end
         default: ;
      endcase
      return passed;
   endfunction

   // Most gaps are zero or short. Some gaps are medium, so that the next
   // request lands on every cycle of the block's scan. A few gaps are long.
   function automatic int sender_gap();
      int roll;
      if (!gaps_enabled)
         return 0;
      roll = $urandom_range(99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(4, 1);
      else if (roll < 96)
         return $urandom_range(24, 5);
      return $urandom_range(90, 30);
   endfunction

   // This drops start for the given number of cycles. The next request
   // raises start again at a later falling edge, so start never gets two
   // assignments in one time step.
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // This sends one request. The fields change at a falling edge. The
   // request is taken at the first rising edge at which busy is low. The
   // expected verdict is queued at that same edge.
   task automatic send_request(input psff_pkg::op_type op,
                               input logic [psff_pkg::ID_W-1:0] id,
                               input logic [psff_pkg::TICK_W-1:0] tick);
      pause_sender(sender_gap());
      @(negedge clock);
      start           <= 1'b1;
      req_op          <= op;
      req_peer_id     <= id;
      req_server_tick <= tick;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_verdicts.push_back('{op, id, tick, predict_freshness(op, id, tick)});
   endtask

   // The sender holds off until every outstanding request has been answered.
   task automatic wait_for_drain();
      pause_sender(1);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // The receiver cannot stall, so each strobe is checked at the edge that
   // ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            note_failure($sformatf("response (accepted %b) with no request pending",
                                   rsp_accepted));
         end else begin
            oldest_verdict = pending_verdicts.pop_front();
            if (rsp_accepted !== oldest_verdict.accepted)
               note_failure($sformatf(
                  "op %0d peer %h tick %h: accepted expected %b, got %b",
                  oldest_verdict.op, oldest_verdict.peer, oldest_verdict.tick,
                  oldest_verdict.accepted, rsp_accepted));
         end
      end
   end

   // A pool of nonzero peer ids, each with a running tick base.
   function automatic void build_pool(input int size);
      int i;
      pool_size = size;
      for (i = 0; i < size; i++) begin
         id_pool[i] = $urandom;
         if (id_pool[i] == '0)
            id_pool[i] = 32'h0000_0001;
         pool_tick[i] = $urandom;
      end
   endfunction

   // The tick is picked near the peer's running base: a little newer, a
   // little older, the same, about half the tick space away, or anywhere.
   function automatic logic [psff_pkg::TICK_W-1:0] pick_tick(input int member);
      int roll;
      logic [psff_pkg::TICK_W-1:0] tick;
      roll = $urandom_range(99);
      if (roll < 40)
         tick = pool_tick[member] + $urandom_range(1000, 1);
      else if (roll < 55)
         tick = pool_tick[member] - $urandom_range(1000, 1);
      else if (roll < 65)
         tick = pool_tick[member];
      else if (roll < 75)
         tick = pool_tick[member] + psff_pkg::SERIAL_HALF - 2 + $urandom_range(3);
      else
         tick = $urandom;
      if (roll < 40 || roll >= 75)
         pool_tick[member] = tick;
      return tick;
   endfunction

   // This runs random traffic over the current pool. Most requests are
   // well formed and use a pool member. A few are noise: a zero id, the
   // unused op, or a stranger that the table has never seen. Noise does
   // not count toward the request total.
   task automatic run_traffic(input int count, input int activate_pct,
                              input int retire_pct);
      int sent;
      int roll;
      int member;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         member = $urandom_range(pool_size - 1);
         if (roll < 2) begin
            send_request(psff_pkg::op_type'($urandom_range(3)), '0, $urandom);
         end else if (roll < 4) begin
            send_request(OP_UNUSED, id_pool[member], $urandom);
         end else if (roll < 6) begin
            send_request(psff_pkg::OP_ACCEPT, $urandom, $urandom);
         end else begin
            if (roll < 6 + activate_pct)
               send_request(psff_pkg::OP_ACTIVATE, id_pool[member], $urandom);
            else if (roll < 6 + activate_pct + retire_pct)
               send_request(psff_pkg::OP_RETIRE, id_pool[member], $urandom);
            else
               send_request(psff_pkg::OP_ACCEPT, id_pool[member], pick_tick(member));
            sent++;
         end
      end
   endtask

   // These steps cover serial order: the first tick of a fresh peer, an
   // equal tick, the wrap from all ones to zero, a gap of exactly half the
   // tick space, and one just below half.
   task automatic test_serial_order();
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h0000_0005);
      send_request(psff_pkg::OP_ACTIVATE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h0000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h8000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h7FFF_FFFE);
   endtask

   // A zero id must not be stored by any op, and the unused op must leave
   // the peer's tick alone. The last accept would fail if the unused op
   // had stored its tick.
   task automatic test_zero_id_and_unused_op();
      send_request(psff_pkg::OP_ACCEPT,   32'h0000_0000, 32'h0000_0001);
      send_request(psff_pkg::OP_ACTIVATE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(psff_pkg::OP_RETIRE,   32'h0000_0000, 32'h0000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_UNUSED,             32'hFFFF_FFFF, 32'h8000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h8000_0000);
   endtask

   // A retired peer rejects updates until it is activated again, and the
   // revive clears its tick history. Retiring a stranger claims a slot that
   // is already retired.
   task automatic test_retire_and_revive();
      send_request(psff_pkg::OP_RETIRE,   32'hFFFF_FFFF, 32'h0000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h8000_0001);
      send_request(psff_pkg::OP_ACTIVATE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'hFFFF_FFFF, 32'h0000_0000);
      send_request(psff_pkg::OP_RETIRE,   32'h0000_0001, 32'hFFFF_FFFF);
      send_request(psff_pkg::OP_ACCEPT,   32'h0000_0001, 32'h0000_0001);
      send_request(psff_pkg::OP_ACTIVATE, 32'h0000_0001, 32'h0000_0000);
      send_request(psff_pkg::OP_ACTIVATE, 32'h0000_0001, 32'h0000_0000);
      send_request(psff_pkg::OP_ACCEPT,   32'h0000_0001, 32'h0000_0001);
   endtask

   // A few peers see long update streams, so the serial order is tested at
   // depth.
   task automatic test_few_peers();
      build_pool(4);
      run_traffic(500, 8, 5);
   endtask

   // More peers than slots, with many activates. The table fills, extra
   // activates and retires are dropped, and retired slots get reused.
   task automatic test_crowded_table();
      build_pool(24);
      run_traffic(500, 25, 12);
   endtask

   // Requests go in back to back, with start held high throughout.
   task automatic test_back_to_back();
      gaps_enabled = 1'b0;
      build_pool(10);
      run_traffic(400, 12, 8);
      gaps_enabled = 1'b1;
   endtask

   // A wide pool has frequent misses and heavy slot churn.
   task automatic test_wide_pool();
      build_pool(POOL_MAX);
      run_traffic(300, 20, 15);
   endtask

   initial begin
      clear_peer_slots();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_serial_order();
      test_zero_id_and_unused_op();
      test_retire_and_revive();
      test_few_peers();
      wait_for_drain();
      test_crowded_table();
      wait_for_drain();
      test_back_to_back();
      test_wide_pool();

      // The sender stops. All responses must come in, and then a quiet
      // stretch catches any stray strobe.
      wait_for_drain();
      repeat (4 * (TABLE_DEPTH + 2)) @(posedge clock);
      if (pending_verdicts.size() != 0)
         note_failure($sformatf("%0d responses never arrived", pending_verdicts.size()));

      if (failure_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
rtl/core/psff_pkg.sv
rtl/core/psff_ram.sv
rtl/core/psff_ctrl.sv
rtl/core/psff_datapath.sv
rtl/core/peer_sequence_freshness_filter.sv
tb/testbench.sv
